FILE: sv/pal_xfer_pkg.sv
// Package for the palette table with stream transfer block.
// Holds the item types, command and status codes, and the default palette tables.
// No dependencies.
package pal_xfer_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  typedef enum logic [2:0] {
    CMD_SET    = 3'd0,
    CMD_READ   = 3'd1,
    CMD_FILL   = 3'd2,
    CMD_LOAD   = 3'd3,
    CMD_STORE  = 3'd4,
    CMD_STREAM = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_CMAP = 3'd1,
    ST_BAD_IDX = 3'd2,
    ST_BAD_SIG = 3'd3,
    ST_NO_XFER = 3'd4
  } status_t;

  typedef enum logic {
    REG_CMAP_FORMAT = 1'b0,
    REG_BPP_MODE    = 1'b1
  } reg_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  first_index;
    logic [7:0]  last_index;
    logic [31:0] color;
    logic [7:0]  byte_in;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] color_out;
    logic [7:0]  byte_out;
    logic        last;
  } rsp_item_t;

  localparam logic [31:0] DEF_MAP_2 [2] = '{32'h000000FF, 32'hFFFFFFFF};

  localparam logic [31:0] DEF_MAP_4 [4] = '{
    32'h000000FF, 32'hFF0000FF, 32'h00FF00FF, 32'hFFFFFFFF
  };

  localparam logic [31:0] DEF_MAP_16 [16] = '{
    32'h000000FF, 32'h000080FF, 32'h008000FF, 32'h008080FF,
    32'h800000FF, 32'h800080FF, 32'h808000FF, 32'h555555FF,
    32'hAAAAAAFF, 32'h0000FFFF, 32'h00FF00FF, 32'h00FFFFFF,
    32'hFF0000FF, 32'hFF00FFFF, 32'hFFFF00FF, 32'hFFFFFFFF
  };

  // Header signature of the stream: 'P', 'A', 'L', 0, 1, 0.
  function automatic logic [7:0] sig_byte(input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0: b = 8'h50;
      3'd1: b = 8'h41;
      3'd2: b = 8'h4C;
      3'd4: b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // RGB332 index expanded to RGBA8888 by bit replication.
  function automatic logic [31:0] rgb332_expand(input logic [7:0] idx);
    logic [2:0] r;
    logic [2:0] g;
    logic [1:0] b;
    r = idx[7:5];
    g = idx[4:2];
    b = idx[1:0];
    return {r, r, r[2:1], g, g, g[2:1], b, b, b, b, 8'hFF};
  endfunction

  function automatic logic [31:0] default_color(input logic [1:0] bpp, input logic [7:0] idx);
    logic [31:0] c;
    case (bpp)
      2'd0: c = DEF_MAP_2[idx[0]];
      2'd1: c = DEF_MAP_4[idx[1:0]];
      2'd2: c = DEF_MAP_16[idx[3:0]];
      default: c = rgb332_expand(idx);
    endcase
    return c;
  endfunction

endpackage

FILE: sv/pal_xfer_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the palette storage; no dependencies.
module pal_xfer_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/palette_table_with_stream_transfer_core.sv
// Top level of the palette table with stream transfer block.
// Depends on pal_xfer_pkg and pal_xfer_ram.
//
// The block keeps a color lookup table of 2, 4, 16 or 256 RGBA words, sized by
// bpp_mode, in one RAM with valid bits so that reset reads back as zero.
// Items arrive on the cmd channel and each one gives exactly one item on the
// rsp channel; both channels use valid and stall. Configuration registers
// cmap_format and bpp_mode sit on the APB port at byte addresses 0 and 4.
// Set entry, begin load, begin store, load bytes and store header bytes are
// done on acceptance, their result going to the holding register and then
// the output register; a new item can be taken every cycle while cmd_stall
// is low. Read entry and store data bytes go through S_READ because of the
// RAM's registered read port, with cmd_stall high until their result is held.
// A default fill writes one entry per cycle with cmd_stall high until the
// table is written. One result waits in a holding register while the output
// register is stalled, so the next item is still accepted; outside a read or
// a fill, cmd_stall rises only when both are full.
// Reset empties both registers, closes any transfer, sets cmap_format to 1 and
// bpp_mode to 3, and marks every entry as zero without a clearing pass.
module palette_table_with_stream_transfer_core #(
  parameter int MAX_ENTRIES = pal_xfer_pkg::MAX_ENTRIES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  output logic                             cmd_stall,
  input  pal_xfer_pkg::cmd_item_t          cmd_item,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output pal_xfer_pkg::rsp_item_t          rsp_item,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pal_xfer_pkg::CFG_AW-1:0]  paddr,
  input  logic [pal_xfer_pkg::CFG_DW-1:0]  pwdata,
  output logic [pal_xfer_pkg::CFG_DW-1:0]  prdata,
  output logic                             pready
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam logic [8:0] MAX_SIZE = 9'(MAX_ENTRIES);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_FILL} state_t;
  typedef enum logic [1:0] {PH_IDLE, PH_LOAD, PH_STORE} phase_t;

  state_t                  state;
  logic                    cmap_format;
  logic [1:0]              bpp_mode;
  phase_t                  phase, phase_next;
  logic                    data_phase, data_phase_next;
  logic [2:0]              byte_pos, byte_pos_next;
  logic [7:0]              cursor, cursor_next;
  logic [7:0]              end_idx, end_idx_next;
  logic [23:0]             word_asm, word_asm_next;
  logic [15:0]             hdr_count, hdr_count_next;
  logic [AW-1:0]           fill_idx;
  logic                    rd_store, rd_store_next;
  logic                    rd_hit;
  logic [MAX_ENTRIES-1:0]  ent_valid;
  logic                    pend_valid;
  pal_xfer_pkg::rsp_item_t pend_item;
  pal_xfer_pkg::rsp_item_t res;
  logic                    res_set;
  logic                    go_read;
  logic                    go_fill;
  logic                    we;
  logic [AW-1:0]           waddr;
  logic [31:0]             wdata;
  logic [AW-1:0]           raddr;
  logic [31:0]             rdata;
  logic [31:0]             rd_word;
  logic [8:0]              tbl_size;
  logic [7:0]              size_last;
  logic [8:0]              span;
  logic [15:0]             hc;
  logic [7:0]              range_end;
  logic                    rsp_free;
  logic                    pend_free;
  logic                    accept;
  logic                    cfg_write;
  logic                    fill_done;

  pal_xfer_ram #(
    .WIDTH(32),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign pend_free = !pend_valid || rsp_free;
  assign cmd_stall = (state != S_IDLE) || !pend_free;
  assign accept    = cmd_valid && !cmd_stall;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      pal_xfer_pkg::REG_CMAP_FORMAT: prdata = {31'd0, cmap_format};
      default: prdata = {30'd0, bpp_mode};
    endcase
  end

  always_comb begin
    case (bpp_mode)
      2'd0: tbl_size = 9'd2;
      2'd1: tbl_size = 9'd4;
      2'd2: tbl_size = 9'd16;
      default: tbl_size = 9'd256;
    endcase
    if (tbl_size > MAX_SIZE) begin
      tbl_size = MAX_SIZE;
    end
  end

  assign size_last = 8'(tbl_size - 9'd1);
  assign span      = {1'b0, end_idx} - {1'b0, cursor} + 9'd1;
  assign hc        = {hdr_count[15:8], cmd_item.byte_in};
  assign rd_word   = rd_hit ? rdata : 32'd0;
  assign fill_done = (8'(fill_idx) == size_last);

  always_comb begin
    if ({1'b0, cmd_item.last_index} >= tbl_size) begin
      range_end = size_last;
    end else if (cmd_item.last_index < cmd_item.first_index) begin
      range_end = cmd_item.first_index;
    end else begin
      range_end = cmd_item.last_index;
    end
  end

  always_comb begin
    phase_next      = phase;
    data_phase_next = data_phase;
    byte_pos_next   = byte_pos;
    cursor_next     = cursor;
    end_idx_next    = end_idx;
    word_asm_next   = word_asm;
    hdr_count_next  = hdr_count;
    rd_store_next   = rd_store;
    res             = '0;
    res_set         = 1'b0;
    go_read         = 1'b0;
    go_fill         = 1'b0;
    we              = 1'b0;
    waddr           = cmd_item.first_index[AW-1:0];
    wdata           = cmd_item.color;
    raddr           = cmd_item.first_index[AW-1:0];
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (!cmap_format) begin
            res.status = pal_xfer_pkg::ST_NO_CMAP;
            res_set    = 1'b1;
          end else begin
            case (cmd_item.cmd)
              pal_xfer_pkg::CMD_SET, pal_xfer_pkg::CMD_READ,
              pal_xfer_pkg::CMD_LOAD, pal_xfer_pkg::CMD_STORE: begin
                if ({1'b0, cmd_item.first_index} >= tbl_size) begin
                  res.status = pal_xfer_pkg::ST_BAD_IDX;
                  res_set    = 1'b1;
                end else if (cmd_item.cmd == pal_xfer_pkg::CMD_SET) begin
                  we      = 1'b1;
                  res_set = 1'b1;
                end else if (cmd_item.cmd == pal_xfer_pkg::CMD_READ) begin
                  go_read       = 1'b1;
                  rd_store_next = 1'b0;
                end else begin
                  phase_next      = (cmd_item.cmd == pal_xfer_pkg::CMD_LOAD) ? PH_LOAD
                                                                              : PH_STORE;
                  data_phase_next = 1'b0;
                  byte_pos_next   = 3'd0;
                  cursor_next     = cmd_item.first_index;
                  end_idx_next    = range_end;
                  word_asm_next   = 24'd0;
                  hdr_count_next  = 16'd0;
                  res_set         = 1'b1;
                end
              end
              pal_xfer_pkg::CMD_FILL: begin
                go_fill = 1'b1;
              end
              pal_xfer_pkg::CMD_STREAM: begin
                case (phase)
                  PH_LOAD: begin
                    res_set = 1'b1;
                    if (!data_phase) begin
                      if (byte_pos < 3'd6) begin
                        if (cmd_item.byte_in != pal_xfer_pkg::sig_byte(byte_pos)) begin
                          res.status      = pal_xfer_pkg::ST_BAD_SIG;
                          res.last        = 1'b1;
                          phase_next      = PH_IDLE;
                          data_phase_next = 1'b0;
                          byte_pos_next   = 3'd0;
                        end else begin
                          byte_pos_next = byte_pos + 3'd1;
                        end
                      end else if (byte_pos == 3'd6) begin
                        hdr_count_next = {cmd_item.byte_in, 8'd0};
                        byte_pos_next  = 3'd7;
                      end else begin
                        hdr_count_next = hc;
                        if (hc == 16'd0) begin
                          res.last        = 1'b1;
                          phase_next      = PH_IDLE;
                          data_phase_next = 1'b0;
                          byte_pos_next   = 3'd0;
                        end else begin
                          if (hc < {7'd0, span}) begin
                            end_idx_next = cursor + hc[7:0] - 8'd1;
                          end
                          data_phase_next = 1'b1;
                          byte_pos_next   = 3'd0;
                        end
                      end
                    end else if (byte_pos < 3'd3) begin
                      word_asm_next = {word_asm[15:0], cmd_item.byte_in};
                      byte_pos_next = byte_pos + 3'd1;
                    end else begin
                      we            = 1'b1;
                      waddr         = cursor[AW-1:0];
                      wdata         = {word_asm, cmd_item.byte_in};
                      byte_pos_next = 3'd0;
                      if (cursor >= end_idx) begin
                        res.last        = 1'b1;
                        phase_next      = PH_IDLE;
                        data_phase_next = 1'b0;
                      end else begin
                        cursor_next = cursor + 8'd1;
                      end
                    end
                  end
                  PH_STORE: begin
                    if (!data_phase) begin
                      res_set = 1'b1;
                      if (byte_pos < 3'd6) begin
                        res.byte_out = pal_xfer_pkg::sig_byte(byte_pos);
                      end else if (byte_pos == 3'd6) begin
                        res.byte_out = {7'd0, span[8]};
                      end else begin
                        res.byte_out = span[7:0];
                      end
                      if (byte_pos == 3'd7) begin
                        data_phase_next = 1'b1;
                        byte_pos_next   = 3'd0;
                      end else begin
                        byte_pos_next = byte_pos + 3'd1;
                      end
                    end else begin
                      go_read       = 1'b1;
                      rd_store_next = 1'b1;
                      raddr         = cursor[AW-1:0];
                    end
                  end
                  default: begin
                    res.status = pal_xfer_pkg::ST_NO_XFER;
                    res_set    = 1'b1;
                  end
                endcase
              end
              default: begin
                res_set = 1'b1;
              end
            endcase
          end
        end
      end
      S_READ: begin
        if (pend_free) begin
          res_set = 1'b1;
          if (rd_store) begin
            case (byte_pos[1:0])
              2'd0: res.byte_out = rd_word[31:24];
              2'd1: res.byte_out = rd_word[23:16];
              2'd2: res.byte_out = rd_word[15:8];
              default: res.byte_out = rd_word[7:0];
            endcase
            if (byte_pos[1:0] != 2'd3) begin
              byte_pos_next = byte_pos + 3'd1;
            end else begin
              byte_pos_next = 3'd0;
              if (cursor >= end_idx) begin
                res.last        = 1'b1;
                phase_next      = PH_IDLE;
                data_phase_next = 1'b0;
              end else begin
                cursor_next = cursor + 8'd1;
              end
            end
          end else begin
            res.color_out = rd_word;
          end
        end
      end
      S_FILL: begin
        we    = 1'b1;
        waddr = fill_idx;
        wdata = pal_xfer_pkg::default_color(bpp_mode, 8'(fill_idx));
        if (fill_done && pend_free) begin
          res_set = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cmap_format <= 1'b1;
      bpp_mode    <= 2'd3;
      phase       <= PH_IDLE;
      data_phase  <= 1'b0;
      byte_pos    <= 3'd0;
      cursor      <= 8'd0;
      end_idx     <= 8'd0;
      word_asm    <= 24'd0;
      hdr_count   <= 16'd0;
      fill_idx    <= '0;
      rd_store    <= 1'b0;
      rd_hit      <= 1'b0;
      ent_valid   <= '0;
      pend_valid  <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (paddr[2])
          pal_xfer_pkg::REG_CMAP_FORMAT: cmap_format <= pwdata[0];
          default: bpp_mode <= pwdata[1:0];
        endcase
      end
      phase      <= phase_next;
      data_phase <= data_phase_next;
      byte_pos   <= byte_pos_next;
      cursor     <= cursor_next;
      end_idx    <= end_idx_next;
      word_asm   <= word_asm_next;
      hdr_count  <= hdr_count_next;
      rd_store   <= rd_store_next;
      if (we) begin
        ent_valid[waddr] <= 1'b1;
      end
      if (go_read) begin
        rd_hit <= ent_valid[raddr];
      end
      case (state)
        S_IDLE: begin
          if (go_read) begin
            state <= S_READ;
          end else if (go_fill) begin
            state    <= S_FILL;
            fill_idx <= '0;
          end
        end
        S_READ: begin
          if (res_set) begin
            state <= S_IDLE;
          end
        end
        S_FILL: begin
          if (res_set) begin
            state <= S_IDLE;
          end else if (!fill_done) begin
            fill_idx <= fill_idx + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (pend_valid && rsp_free) begin
        rsp_valid <= 1'b1;
        rsp_item  <= pend_item;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (res_set) begin
        pend_valid <= 1'b1;
        pend_item  <= res;
      end else if (pend_valid && rsp_free) begin
        pend_valid <= 1'b0;
      end
    end
  end

endmodule
